// File: rtl/core/eatrm_pkg.sv
// ----------------------------------------------------------------------------
// eatrm_pkg
// Shared constants, types and tables for the Euler angle to rotation matrix
// block.
// ----------------------------------------------------------------------------
package eatrm_pkg;

    localparam int ANGLE_BITS   = 16;
    localparam int FRAC_BITS    = 14;
    localparam int CORDIC_STEPS = 16;
    localparam int ELEM_BITS    = 16;
    localparam int Q30_BITS     = 34;
    localparam int Z_BITS       = 34;
    localparam int NUM_LANES    = 3;

    localparam logic signed [Q30_BITS-1:0] CORDIC_X0 = 34'sd652032874;

    typedef logic signed [Q30_BITS-1:0]  q30_t;
    typedef logic signed [ELEM_BITS-1:0] elem_t;
    typedef logic signed [ANGLE_BITS-1:0] angle_t;

    typedef struct packed {
        q30_t sin_v;
        q30_t cos_v;
    } sincos_t;

    function automatic logic signed [Z_BITS-1:0] atan_entry(input int i);
        logic signed [Z_BITS-1:0] v;
        case (i)
            0:  v = 34'sd536870912;
            1:  v = 34'sd316933406;
            2:  v = 34'sd167458907;
            3:  v = 34'sd85004756;
            4:  v = 34'sd42667331;
            5:  v = 34'sd21354465;
            6:  v = 34'sd10679838;
            7:  v = 34'sd5340245;
            8:  v = 34'sd2670163;
            9:  v = 34'sd1335087;
            10: v = 34'sd667544;
            11: v = 34'sd333772;
            12: v = 34'sd166886;
            13: v = 34'sd83443;
            14: v = 34'sd41722;
            15: v = 34'sd20861;
            16: v = 34'sd10430;
            17: v = 34'sd5215;
            18: v = 34'sd2608;
            19: v = 34'sd1304;
            20: v = 34'sd652;
            21: v = 34'sd326;
            22: v = 34'sd163;
            23: v = 34'sd81;
            24: v = 34'sd41;
            25: v = 34'sd20;
            26: v = 34'sd10;
            27: v = 34'sd5;
            28: v = 34'sd3;
            29: v = 34'sd1;
            30: v = 34'sd1;
            default: v = 34'sd0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/core/eatrm_cordic.sv
// ----------------------------------------------------------------------------
// eatrm_cordic
// Pipelined rotation-mode CORDIC lane: one binary angle in, sine and cosine
// in Q30 out, one stage per iteration plus input and output stages.
// ----------------------------------------------------------------------------
module eatrm_cordic
(
    input  logic                clk,
    input  eatrm_pkg::angle_t   angle,
    output eatrm_pkg::sincos_t  result
);
    import eatrm_pkg::*;

    localparam int DEPTH = CORDIC_STEPS + 1;

    q30_t                    x_reg [DEPTH];
    q30_t                    y_reg [DEPTH];
    logic signed [Z_BITS-1:0] z_reg [DEPTH];
    logic [1:0]              q_reg [DEPTH];
    sincos_t                 result_reg;

    logic [31:0] phase;
    logic [31:0] phase_off;
    logic [1:0]  quad;
    logic [31:0] resid;

    assign phase     = {angle, {(32-ANGLE_BITS){1'b0}}};
    assign phase_off = phase + 32'h2000_0000;
    assign quad      = phase_off[31:30];
    assign resid     = phase - {quad, 30'd0};

    always_ff @(posedge clk)
    begin
        x_reg[0] <= CORDIC_X0;
        y_reg[0] <= '0;
        z_reg[0] <= Z_BITS'(signed'(resid));
        q_reg[0] <= quad;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            if (!z_reg[i][Z_BITS-1])
            begin
                x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] - atan_entry(i);
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] + atan_entry(i);
            end
            q_reg[i+1] <= q_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        case (q_reg[CORDIC_STEPS])
            2'd0:
            begin
                result_reg.cos_v <= x_reg[CORDIC_STEPS];
                result_reg.sin_v <= y_reg[CORDIC_STEPS];
            end
            2'd1:
            begin
                result_reg.cos_v <= -y_reg[CORDIC_STEPS];
                result_reg.sin_v <= x_reg[CORDIC_STEPS];
            end
            2'd2:
            begin
                result_reg.cos_v <= -x_reg[CORDIC_STEPS];
                result_reg.sin_v <= -y_reg[CORDIC_STEPS];
            end
            default:
            begin
                result_reg.cos_v <= y_reg[CORDIC_STEPS];
                result_reg.sin_v <= -x_reg[CORDIC_STEPS];
            end
        endcase
    end

    assign result = result_reg;

endmodule

// File: rtl/core/eatrm_merge.sv
// ----------------------------------------------------------------------------
// eatrm_merge
// Combines the three lanes' sines and cosines into the nine matrix elements:
// pair products, rounding, triple products, sums, rounding, clamp, and a transpose when action is set.
// ----------------------------------------------------------------------------
module eatrm_merge
(
    input  logic                clk,
    input  eatrm_pkg::sincos_t  roll_sc,
    input  eatrm_pkg::sincos_t  pitch_sc,
    input  eatrm_pkg::sincos_t  yaw_sc,
    input  logic                action,
    output eatrm_pkg::elem_t    m_out [9]
);
    import eatrm_pkg::*;

    localparam int SH = 60 - FRAC_BITS;

    typedef logic signed [67:0] p_t;

    function automatic elem_t finish(input p_t v);
        p_t r;
        p_t lim;
        r   = (v + (p_t'(1) <<< (SH - 1))) >>> SH;
        lim = p_t'(1) <<< FRAC_BITS;
        if (r > lim)
            r = lim;
        if (r < -lim)
            r = -lim;
        return r[ELEM_BITS-1:0];
    endfunction

    // stage 1: pair products
    q30_t sr_reg, cr_reg, sp_reg, cp_reg, sy_reg, cy_reg;
    p_t   srsp_reg, crsp_reg, cpcy_reg, cpsy_reg, srcp_reg, crcp_reg;
    logic act1_reg;

    always_ff @(posedge clk)
    begin
        srsp_reg <= p_t'(roll_sc.sin_v) * p_t'(pitch_sc.sin_v);
        crsp_reg <= p_t'(roll_sc.cos_v) * p_t'(pitch_sc.sin_v);
        cpcy_reg <= p_t'(pitch_sc.cos_v) * p_t'(yaw_sc.cos_v);
        cpsy_reg <= p_t'(pitch_sc.cos_v) * p_t'(yaw_sc.sin_v);
        srcp_reg <= p_t'(roll_sc.sin_v) * p_t'(pitch_sc.cos_v);
        crcp_reg <= p_t'(roll_sc.cos_v) * p_t'(pitch_sc.cos_v);
        sr_reg   <= roll_sc.sin_v;
        cr_reg   <= roll_sc.cos_v;
        sp_reg   <= pitch_sc.sin_v;
        cp_reg   <= pitch_sc.cos_v;
        sy_reg   <= yaw_sc.sin_v;
        cy_reg   <= yaw_sc.cos_v;
        act1_reg <= action;
    end

    // stage 2: round pairs to Q30 and second-level products
    q30_t srsp_q, crsp_q;
    assign srsp_q = q30_t'((srsp_reg + (p_t'(1) <<< 29)) >>> 30);
    assign crsp_q = q30_t'((crsp_reg + (p_t'(1) <<< 29)) >>> 30);

    p_t a21_reg, b21_reg, a22_reg, b22_reg, a31_reg, b31_reg, a32_reg, b32_reg;
    p_t m11_reg, m12_reg, m13_reg, m23_reg, m33_reg;
    logic act2_reg;

    always_ff @(posedge clk)
    begin
        a21_reg  <= p_t'(srsp_q) * p_t'(cy_reg);
        b21_reg  <= p_t'(cr_reg) * p_t'(sy_reg);
        a22_reg  <= p_t'(srsp_q) * p_t'(sy_reg);
        b22_reg  <= p_t'(cr_reg) * p_t'(cy_reg);
        a31_reg  <= p_t'(crsp_q) * p_t'(cy_reg);
        b31_reg  <= p_t'(sr_reg) * p_t'(sy_reg);
        a32_reg  <= p_t'(crsp_q) * p_t'(sy_reg);
        b32_reg  <= p_t'(sr_reg) * p_t'(cy_reg);
        m11_reg  <= cpcy_reg;
        m12_reg  <= cpsy_reg;
        m13_reg  <= -(p_t'(sp_reg) <<< 30);
        m23_reg  <= srcp_reg;
        m33_reg  <= crcp_reg;
        act2_reg <= act1_reg;
    end

    // stage 3: sums, rounding, clamp, transpose
    elem_t e [9];
    elem_t out_reg [9];

    always_comb
    begin
        e[0] = finish(m11_reg);
        e[1] = finish(m12_reg);
        e[2] = finish(m13_reg);
        e[3] = finish(a21_reg - b21_reg);
        e[4] = finish(a22_reg + b22_reg);
        e[5] = finish(m23_reg);
        e[6] = finish(a31_reg + b31_reg);
        e[7] = finish(a32_reg - b32_reg);
        e[8] = finish(m33_reg);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                out_reg[i*3+j] <= act2_reg ? e[j*3+i] : e[i*3+j];
            end
        end
    end

    assign m_out = out_reg;

endmodule

// File: rtl/core/euler_angles_to_rotation_matrix.sv
// ----------------------------------------------------------------------------
// euler_angles_to_rotation_matrix
// ZYX direction cosine matrix from roll, pitch and yaw binary angles.
// ----------------------------------------------------------------------------
// Usage: raise start with action and the three angles; the request is taken
// at that edge since busy is always low (fully pipelined). Three CORDIC lanes,
// one per angle, run side by side; a merge pipeline forms the nine elements.
// done rises with m11..m33 as the request leaves the last of 21 register
// stages (1 input stage, 16 CORDIC stages, 1 quadrant stage, 3 merge stages
// including the output register). Throughput: one request per cycle.
// done and the results hold for one cycle only; the receiver cannot stall.
// Reset clears the valid pipeline so no stray done appears; data registers
// are not reset.
// ----------------------------------------------------------------------------
module euler_angles_to_rotation_matrix
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 action,
    input  eatrm_pkg::angle_t    roll_angle,
    input  eatrm_pkg::angle_t    pitch_angle,
    input  eatrm_pkg::angle_t    yaw_angle,
    output logic                 done,
    output eatrm_pkg::elem_t     m11,
    output eatrm_pkg::elem_t     m12,
    output eatrm_pkg::elem_t     m13,
    output eatrm_pkg::elem_t     m21,
    output eatrm_pkg::elem_t     m22,
    output eatrm_pkg::elem_t     m23,
    output eatrm_pkg::elem_t     m31,
    output eatrm_pkg::elem_t     m32,
    output eatrm_pkg::elem_t     m33
);
    import eatrm_pkg::*;

    localparam int LANE_LAT = CORDIC_STEPS + 2;
    localparam int TOTAL_LAT = LANE_LAT + 3;

    sincos_t lane_sc [NUM_LANES];
    angle_t  lane_ang [NUM_LANES];
    elem_t   m_out [9];

    logic [TOTAL_LAT-1:0] vld_reg;
    logic [LANE_LAT-1:0]  act_reg;

    assign busy = 1'b0;

    assign lane_ang[0] = roll_angle;
    assign lane_ang[1] = pitch_angle;
    assign lane_ang[2] = yaw_angle;

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        eatrm_cordic u_cordic
        (
            .clk    (clk),
            .angle  (lane_ang[g]),
            .result (lane_sc[g])
        );
    end

    always_ff @(posedge clk)
    begin
        act_reg <= {act_reg[LANE_LAT-2:0], action};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[TOTAL_LAT-2:0], start};
    end

    eatrm_merge u_merge
    (
        .clk      (clk),
        .roll_sc  (lane_sc[0]),
        .pitch_sc (lane_sc[1]),
        .yaw_sc   (lane_sc[2]),
        .action   (act_reg[LANE_LAT-1]),
        .m_out    (m_out)
    );

    assign done = vld_reg[TOTAL_LAT-1];
    assign m11  = m_out[0];
    assign m12  = m_out[1];
    assign m13  = m_out[2];
    assign m21  = m_out[3];
    assign m22  = m_out[4];
    assign m23  = m_out[5];
    assign m31  = m_out[6];
    assign m32  = m_out[7];
    assign m33  = m_out[8];

endmodule
